### design/lcfc_pkg.sv
// shared types, constants and crc helpers for the length and crc frame checker
package lcfc_pkg;

    // verdict codes
    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_BAD = 2'd1,
        STATUS_CRC = 2'd2
    } status_t;

    // one result transfer
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        frame_done;
        status_t     status;
        logic [14:0] frame_tag;
        logic [15:0] body_len;
    } lcfc_result_t;

    localparam int unsigned COUNT_W      = 17;
    localparam logic [COUNT_W-1:0] MIN_FRAME_LEN = 17'd6;
    localparam logic [COUNT_W-1:0] PAYLOAD_START = 17'd4;
    localparam logic [15:0] OVERHEAD_LEN  = 16'd6;
    localparam logic [15:0] CRC_LEN       = 16'd2;
    localparam logic [14:0] ID_REMAP_BASE = 15'd5000;

    // crc-16/arc nibble table, reflected poly 0xA001
    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'hCC01, 16'hD801, 16'h1400, 16'hF001, 16'h3C00, 16'h2800, 16'hE401,
        16'hA001, 16'h6C00, 16'h7800, 16'hB401, 16'h5000, 16'h9C01, 16'h8801, 16'h4400
    };

    // one nibble step of the reflected crc
    function automatic logic [15:0] nib_step(input logic [15:0] c, input logic [3:0] nib);
        nib_step = {4'h0, c[15:4]} ^ NIB_TABLE[c[3:0]] ^ NIB_TABLE[nib];
    endfunction

    // fold one byte, low nibble first
    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] mid;
        mid      = nib_step(c, b[3:0]);
        crc_byte = nib_step(mid, b[7:4]);
    endfunction

endpackage

### design/lcfc_core.sv
// frame state, running crc and verdict logic for one byte per step
module lcfc_core import lcfc_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step_en,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    output lcfc_result_t result
);

    logic [15:0]        crc_reg, crc_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [15:0]        length_reg, length_next;
    logic [15:0]        id_reg, id_next;
    logic [7:0]         newer_reg, newer_next;
    logic [7:0]         older_reg, older_next;

    logic [COUNT_W-1:0] pos;
    logic [15:0]        len_cur;
    logic [15:0]        id_cur;
    logic [15:0]        crc_upd;
    logic [COUNT_W-1:0] n_cur;
    logic [15:0]        rx_crc;
    logic               bad_frame;

    // header capture, crc fold and counter
    always_comb begin
        pos     = count_reg;
        len_cur = length_reg;
        id_cur  = id_reg;
        case (pos)
            17'd0:   len_cur = {length_reg[15:8], data_byte};
            17'd1:   len_cur = {data_byte, length_reg[7:0]};
            17'd2:   id_cur  = {id_reg[15:8], data_byte};
            17'd3:   id_cur  = {data_byte, id_reg[7:0]};
            default: ;
        endcase

        crc_upd = (pos >= 17'd2) ? crc_byte(crc_reg, older_reg) : crc_reg;
        n_cur   = pos[COUNT_W-1] ? pos : pos + 17'd1;
        rx_crc  = {data_byte, newer_reg};

        bad_frame = (n_cur < MIN_FRAME_LEN) || n_cur[COUNT_W-1]
                    || ({1'b0, len_cur} != n_cur);
    end

    // result fields
    always_comb begin
        result               = '0;
        result.payload_byte  = data_byte;
        result.payload_valid = (pos >= PAYLOAD_START) && (len_cur >= OVERHEAD_LEN)
                               && (pos < {1'b0, len_cur - CRC_LEN});
        result.frame_done    = last_byte;
        result.status        = STATUS_OK;
        if (last_byte) begin
            if (bad_frame) begin
                result.status = STATUS_BAD;
            end else if (rx_crc != crc_upd) begin
                result.status = STATUS_CRC;
            end else begin
                result.frame_tag = id_cur[15] ? (15'(id_cur[7:0]) + ID_REMAP_BASE)
                                              : id_cur[14:0];
                result.body_len  = n_cur[15:0] - OVERHEAD_LEN;
            end
        end
    end

    // next state, cleared after the final byte
    always_comb begin
        crc_next    = crc_upd;
        count_next  = n_cur;
        length_next = len_cur;
        id_next     = id_cur;
        older_next  = newer_reg;
        newer_next  = data_byte;
        if (last_byte) begin
            crc_next    = '0;
            count_next  = '0;
            length_next = '0;
            id_next     = '0;
            older_next  = '0;
            newer_next  = '0;
        end
    end

    // frame state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= '0;
            count_reg  <= '0;
            length_reg <= '0;
            id_reg     <= '0;
            newer_reg  <= '0;
            older_reg  <= '0;
        end else if (step_en) begin
            crc_reg    <= crc_next;
            count_reg  <= count_next;
            length_reg <= length_next;
            id_reg     <= id_next;
            newer_reg  <= newer_next;
            older_reg  <= older_next;
        end
    end

endmodule

### design/length_crc_frame_checker.sv
// length and crc-16/arc frame checker, top level with input and result registers
// each byte passes through the input register and then the result register, which loads when empty or being taken
// throughput: one byte per cycle while m_tready holds; the crc folds a whole byte as two nibble lookups
// the input register refills in the same cycle that the result register drains
// reset (aresetn low, synchronous) empties both registers and clears the frame state
module length_crc_frame_checker import lcfc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [9:8] status,
                                   // [24:10] frame_tag, [40:25] body_len, zero fill
    output logic        m_tuser,   // payload_valid
    output logic        m_tlast    // frame_done
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    lcfc_result_t out_reg;
    lcfc_result_t core_result;
    logic         advance;

    // move an item to the result register when it is empty or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    lcfc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .data_byte (in_byte_reg),
        .last_byte (in_last_reg),
        .result    (core_result)
    );

    // input register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    // input register payload
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // result register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= core_result;
        end
    end

    // pack result transfer
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_reg.body_len, out_reg.frame_tag,
                       out_reg.status, out_reg.payload_byte};
    assign m_tuser  = out_reg.payload_valid;
    assign m_tlast  = out_reg.frame_done;

endmodule
